// ===== rtl/core/miller_rabin_primality_test_assert.svh =====
// Assertion macros shared by the primality tester RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef MILLER_RABIN_PRIMALITY_TEST_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_TEST_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MRPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define MRPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mrpt_pkg.sv =====
// Package for the primality tester: datapath commands, status struct,
// controller states and the witness base table. No dependencies.
package mrpt_pkg;

    localparam int BASE_IDX_W = 4;
    localparam int BASE_W     = 8;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_HALVE,
        DP_POW_INIT,
        DP_MUL_AB,
        DP_MUL_BB,
        DP_SHIFT_E,
        DP_MUL_AA,
        DP_NEXT_BASE,
        DP_J_INIT,
        DP_J_INC
    } dp_op_t;

    typedef struct packed {
        logic reject;
        logic d_even;
        logic base_end;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic acc_nm1;
        logic j_lt_s;
        logic mul_done;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HALVE,
        ST_BASE_CHK,
        ST_POW_TEST,
        ST_WAIT_AB,
        ST_ISSUE_BB,
        ST_WAIT_BB,
        ST_CHECK_X,
        ST_SQ_TEST,
        ST_WAIT_AA,
        ST_SQ_CHK
    } ctrl_state_t;

    // Witness bases: the first thirteen primes.
    function automatic logic [BASE_W-1:0] base_at(input logic [BASE_IDX_W-1:0] idx);
        logic [BASE_W-1:0] v;
        begin
            case (idx)
                4'd0:    v = 8'd2;
                4'd1:    v = 8'd3;
                4'd2:    v = 8'd5;
                4'd3:    v = 8'd7;
                4'd4:    v = 8'd11;
                4'd5:    v = 8'd13;
                4'd6:    v = 8'd17;
                4'd7:    v = 8'd19;
                4'd8:    v = 8'd23;
                4'd9:    v = 8'd29;
                4'd10:   v = 8'd31;
                4'd11:   v = 8'd37;
                4'd12:   v = 8'd41;
                default: v = 8'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/core/mrpt_mulmod.sv =====
// Bit-serial modular multiplier: (x * y) mod m by double-and-add.
// Depends on nothing but its parameter; used by mrpt_datapath.
module mrpt_mulmod #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] prod
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic          phase_reg, phase_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  m_reg, m_next;
    logic [W-1:0]  addend;
    logic [W-1:0]  room;
    logic [W-1:0]  sum;
    logic          last_bit;

    // One modular addition per cycle: phase 0 doubles, phase 1 adds x.
    assign addend   = phase_reg ? x_reg : acc_reg;
    assign room     = m_reg - addend;
    assign sum      = (acc_reg >= room) ? (acc_reg - room) : (acc_reg + addend);
    assign last_bit = (cnt_reg == '0);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        m_next     = m_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = CW'(W - 1);
            acc_next   = '0;
            x_next     = x;
            y_next     = y;
            m_next     = m;
        end
        else if (busy_reg)
        begin
            acc_next = sum;
            if (!phase_reg && y_reg[W-1])
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                if (last_bit)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    y_next   = {y_reg[W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        m_reg   <= m_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/mrpt_datapath.sv =====
// Datapath of the primality tester: candidate, d, s, exponent, accumulator
// and base registers plus the modular multiplier. Uses mrpt_pkg, mrpt_mulmod.
module mrpt_datapath
    import mrpt_pkg::*;
#(
    parameter int W         = 64,
    parameter int NUM_BASES = 13
) (
    input  logic         clk,
    input  logic         rst_n,
    input  dp_op_t       op,
    input  logic [W-1:0] candidate,
    output dp_status_t   status
);

    localparam int SW = $clog2(W + 1);
    localparam int IW = $clog2(NUM_BASES + 1);

    logic [W-1:0]  n_reg, nm1_reg, d_reg, e_reg, acc_reg, b_reg;
    logic [SW-1:0] s_reg, j_reg;
    logic [IW-1:0] i_reg;
    logic          dest_b_reg;
    logic [W-1:0]  base_ext;
    logic          mul_start;
    logic [W-1:0]  mul_x, mul_y, mul_prod;
    logic          mul_done;

    assign base_ext  = W'(base_at(BASE_IDX_W'(i_reg)));
    assign mul_start = (op == DP_MUL_AB) || (op == DP_MUL_BB) || (op == DP_MUL_AA);
    assign mul_x     = (op == DP_MUL_BB) ? b_reg : acc_reg;
    assign mul_y     = (op == DP_MUL_AA) ? acc_reg : b_reg;

    mrpt_mulmod #(.W(W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .m     (n_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_b_reg <= 1'b0;
        end
        else if (mul_start)
        begin
            dest_b_reg <= (op == DP_MUL_BB);
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            DP_LOAD:
            begin
                n_reg   <= candidate;
                nm1_reg <= candidate - 1'b1;
                d_reg   <= candidate - 1'b1;
                s_reg   <= '0;
                i_reg   <= '0;
            end
            DP_HALVE:
            begin
                d_reg <= d_reg >> 1;
                s_reg <= s_reg + 1'b1;
            end
            DP_POW_INIT:
            begin
                acc_reg <= W'(1);
                b_reg   <= base_ext;
                e_reg   <= d_reg;
            end
            DP_SHIFT_E:   e_reg <= e_reg >> 1;
            DP_NEXT_BASE: i_reg <= i_reg + 1'b1;
            DP_J_INIT:    j_reg <= SW'(1);
            DP_J_INC:     j_reg <= j_reg + 1'b1;
            default:      ;
        endcase
        if (mul_done)
        begin
            if (dest_b_reg)
            begin
                b_reg <= mul_prod;
            end
            else
            begin
                acc_reg <= mul_prod;
            end
        end
    end

    assign status.reject   = (n_reg < W'(2)) || ((n_reg != W'(2)) && !n_reg[0]);
    assign status.d_even   = !d_reg[0] && (d_reg != '0);
    assign status.base_end = (i_reg >= IW'(NUM_BASES)) || (base_ext >= nm1_reg);
    assign status.e_zero   = (e_reg == '0);
    assign status.e_lsb    = e_reg[0];
    assign status.acc_one  = (acc_reg == W'(1));
    assign status.acc_nm1  = (acc_reg == nm1_reg);
    assign status.j_lt_s   = (j_reg < s_reg);
    assign status.mul_done = mul_done;

endmodule

// ===== rtl/core/mrpt_ctrl.sv =====
// Controller state machine of the primality tester: sequences the datapath
// and raises the result strobe. Uses mrpt_pkg.
module mrpt_ctrl
    import mrpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_op_t     op,
    output logic       busy,
    output logic       done,
    output logic       is_prime
);

    ctrl_state_t state_reg, state_next;
    logic        done_reg, done_next;
    logic        prime_reg, prime_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            prime_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            prime_reg <= prime_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = DP_NONE;
        done_next  = 1'b0;
        prime_next = prime_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = DP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.reject)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HALVE;
                end
            end
            ST_HALVE:
            begin
                if (status.d_even)
                begin
                    op = DP_HALVE;
                end
                else
                begin
                    state_next = ST_BASE_CHK;
                end
            end
            ST_BASE_CHK:
            begin
                if (status.base_end)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    op         = DP_POW_INIT;
                    state_next = ST_POW_TEST;
                end
            end
            ST_POW_TEST:
            begin
                if (status.e_zero)
                begin
                    state_next = ST_CHECK_X;
                end
                else if (status.e_lsb)
                begin
                    op         = DP_MUL_AB;
                    state_next = ST_WAIT_AB;
                end
                else
                begin
                    op         = DP_MUL_BB;
                    state_next = ST_WAIT_BB;
                end
            end
            ST_WAIT_AB:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_ISSUE_BB;
                end
            end
            ST_ISSUE_BB:
            begin
                op         = DP_MUL_BB;
                state_next = ST_WAIT_BB;
            end
            ST_WAIT_BB:
            begin
                if (status.mul_done)
                begin
                    op         = DP_SHIFT_E;
                    state_next = ST_POW_TEST;
                end
            end
            ST_CHECK_X:
            begin
                if (status.acc_one || status.acc_nm1)
                begin
                    op         = DP_NEXT_BASE;
                    state_next = ST_BASE_CHK;
                end
                else
                begin
                    op         = DP_J_INIT;
                    state_next = ST_SQ_TEST;
                end
            end
            ST_SQ_TEST:
            begin
                if (status.j_lt_s)
                begin
                    op         = DP_MUL_AA;
                    state_next = ST_WAIT_AA;
                end
                else
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT_AA:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_SQ_CHK;
                end
            end
            ST_SQ_CHK:
            begin
                if (status.acc_one)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (status.acc_nm1)
                begin
                    op         = DP_NEXT_BASE;
                    state_next = ST_BASE_CHK;
                end
                else
                begin
                    op         = DP_J_INC;
                    state_next = ST_SQ_TEST;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule

// ===== rtl/core/miller_rabin_primality_test.sv =====
// Top level of the deterministic Miller-Rabin primality tester.
// Depends on mrpt_pkg, mrpt_ctrl, mrpt_datapath and the assertion header.
//
// Usage: drive candidate and raise start while busy is low; that edge takes
// the beat. Bits of candidate at or above NUM_WIDTH are ignored. busy stays
// high until the answer is ready. The answer appears on is_prime and is held
// there; done marks it for exactly one cycle; the receiver cannot stall, so
// it must capture the beat in that cycle. busy is already low while done is
// high, so a new start may be given in the same cycle that the answer shows.
//
// Run time: zero, one and even values above two are rejected in the check
// state, which registers done and returns to idle. Otherwise the time is
// set by the bit-serial modular multiplier, which does one doubling for each
// of the NUM_WIDTH bits of its second operand and one addition per set bit.
// Each tried base costs one product per bit of d, one more per set bit of d,
// and up to s-1 squarings, where candidate-1 = d*2^s. A 64-bit prime runs
// all thirteen bases. The block works on one candidate at a time.
//
// Reset (rst_n low, asynchronous) returns the controller to idle and drops
// busy and done; no answer in progress is delivered.
module miller_rabin_primality_test
    import mrpt_pkg::*;
#(
    parameter int NUM_WIDTH = 64,
    parameter int NUM_BASES = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [NUM_WIDTH-1:0] candidate,
    output logic                 done,
    output logic                 is_prime
);

    `include "miller_rabin_primality_test_assert.svh"

    dp_op_t     op;
    dp_status_t status;

    // The controller owns sequencing; the datapath holds every wide value.
    mrpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .op       (op),
        .busy     (busy),
        .done     (done),
        .is_prime (is_prime)
    );

    mrpt_datapath #(
        .W         (NUM_WIDTH),
        .NUM_BASES (NUM_BASES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .candidate (candidate),
        .status    (status)
    );

    // An accepted beat always makes the block busy in the next cycle.
    `MRPT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // The result strobe lasts a single cycle.
    `MRPT_ASSERT_NEXT(a_done_pulse, done, !done)
    // An answer is shown only once the controller is back in idle.
    `MRPT_ASSERT_IMP(a_done_idle, done, !busy)

endmodule
